[design/lgs_pkg.sv]
// Package with the constants, command and status types and the grayscale map of the serializer.
package lgs_pkg;

  localparam int LAYER_COUNT  = 3;
  localparam int CHANNELS     = 27;
  localparam int STORE_DEPTH  = LAYER_COUNT * CHANNELS;
  localparam int GRAY_W       = 12;
  localparam int BYTE_W       = 8;
  localparam int UPLOAD_BYTES = (CHANNELS * GRAY_W + BYTE_W - 1) / BYTE_W;
  localparam int PAD_BITS     = UPLOAD_BYTES * BYTE_W - CHANNELS * GRAY_W;
  localparam int ACC_W        = GRAY_W + BYTE_W;

  localparam int IDX_W   = 7;
  localparam int VAL_W   = 8;
  localparam int SHOWN_W = 2;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int LAYER_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int CH_W    = $clog2(CHANNELS);
  localparam int BCNT_W  = $clog2(UPLOAD_BYTES);
  localparam int NBITS_W = $clog2(ACC_W + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic               start;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               fetch;
    logic [ADDR_W-1:0]  rd_addr;
    logic               append;
    logic               emit;
    logic               last;
    logic [SHOWN_W-1:0] shown;
  } dp_cmd_t;

  typedef struct packed {
    logic bits_ge8;
    logic bits_le8;
    logic bits_le16;
    logic out_free;
  } dp_status_t;

  // Maps an 8-bit brightness to 12 bits: 16*v plus v/17 rounded to nearest.
  function automatic logic [GRAY_W-1:0] gray_map(input logic [VAL_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int k = 1; k <= 15; k++) begin
      if (int'(v) >= 17 * k - 8) begin
        r = r + 4'd1;
      end
    end
    return {v, 4'b0000} + {{(GRAY_W - 4){1'b0}}, r};
  endfunction

endpackage

[design/lgs_if.sv]
// Handshake interfaces for the input and result channels of the serializer.
interface lgs_in_if;
  import lgs_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] pixel_index;
  logic [VAL_W-1:0] pixel_value;

  modport source (output valid, output command, output pixel_index, output pixel_value,
                  input ready);
  modport sink (input valid, input command, input pixel_index, input pixel_value,
                output ready);
endinterface

interface lgs_out_if;
  import lgs_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  shift_byte;
  logic               last_byte;
  logic [SHOWN_W-1:0] shown_layer;

  modport source (output valid, output shift_byte, output last_byte, output shown_layer,
                  input ready);
  modport sink (input valid, input shift_byte, input last_byte, input shown_layer,
                output ready);
endinterface

[design/lgs_ctrl.sv]
// Controller: layer counter, upload sequencing and datapath commands.
module lgs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_command,
  input  logic [lgs_pkg::IDX_W-1:0] in_pixel_index,
  output logic                   in_ready,
  input  lgs_pkg::dp_status_t    status,
  output lgs_pkg::dp_cmd_t       cmd
);
  import lgs_pkg::*;

  state_t             state_r, state_nxt;
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic [SHOWN_W-1:0] shown_r, shown_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic               fetch_done_r, fetch_done_nxt;
  logic               pend_r, pend_nxt;
  logic [BCNT_W-1:0]  byte_r, byte_nxt;

  logic accept;
  logic room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      layer_r      <= '0;
      shown_r      <= '0;
      ch_r         <= '0;
      fetch_done_r <= 1'b0;
      pend_r       <= 1'b0;
      byte_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      layer_r      <= layer_nxt;
      shown_r      <= shown_nxt;
      ch_r         <= ch_nxt;
      fetch_done_r <= fetch_done_nxt;
      pend_r       <= pend_nxt;
      byte_r       <= byte_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    layer_nxt      = layer_r;
    shown_nxt      = shown_r;
    ch_nxt         = ch_r;
    fetch_done_nxt = fetch_done_r;
    pend_nxt       = pend_r;
    byte_nxt       = byte_r;
    cmd            = '0;
    cmd.shown      = shown_r;
    cmd.wr_addr    = ADDR_W'(in_pixel_index);
    cmd.rd_addr    = ADDR_W'(int'(layer_r) * CHANNELS + int'(ch_r));
    in_ready       = 1'b0;
    accept         = 1'b0;
    room           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept && in_command == CMD_WRITE) begin
          cmd.wr_en = int'(in_pixel_index) < STORE_DEPTH;
        end else if (accept && in_command == CMD_TICK) begin
          cmd.start      = 1'b1;
          shown_nxt      = SHOWN_W'(layer_r);
          layer_nxt      = (int'(layer_r) + 1 >= LAYER_COUNT) ? '0 : layer_r + 1'b1;
          ch_nxt         = CH_W'(CHANNELS - 1);
          fetch_done_nxt = 1'b0;
          pend_nxt       = 1'b0;
          byte_nxt       = '0;
          state_nxt      = ST_STREAM;
        end
      end
      ST_STREAM: begin
        cmd.emit   = status.bits_ge8 && status.out_free;
        room       = cmd.emit ? status.bits_le16 : status.bits_le8;
        cmd.append = pend_r && room;
        cmd.fetch  = !fetch_done_r && (!pend_r || cmd.append);
        cmd.last   = int'(byte_r) == UPLOAD_BYTES - 1;
        if (cmd.fetch) begin
          pend_nxt = 1'b1;
          if (ch_r == '0) begin
            fetch_done_nxt = 1'b1;
          end else begin
            ch_nxt = ch_r - 1'b1;
          end
        end else if (cmd.append) begin
          pend_nxt = 1'b0;
        end
        if (cmd.emit) begin
          byte_nxt = byte_r + 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/lgs_datapath.sv]
// Datapath: frame memory, grayscale map, bit packer and output register.
module lgs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lgs_pkg::VAL_W-1:0]  in_pixel_value,
  input  lgs_pkg::dp_cmd_t           cmd,
  output lgs_pkg::dp_status_t        status,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [lgs_pkg::BYTE_W-1:0] out_shift_byte,
  output logic                       out_last_byte,
  output logic [lgs_pkg::SHOWN_W-1:0] out_shown_layer
);
  import lgs_pkg::*;

  logic [VAL_W-1:0]       mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r, valid_nxt;
  logic [VAL_W-1:0]       rd_data_r;
  logic                   rd_hit_r;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [NBITS_W-1:0] nbits_r, nbits_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;
  logic [SHOWN_W-1:0] shown_r;

  logic [VAL_W-1:0]  pix;
  logic [GRAY_W-1:0] gray;
  logic [BYTE_W-1:0] emit_byte;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= in_pixel_value;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[cmd.rd_addr];
      rd_hit_r  <= valid_r[cmd.rd_addr];
    end
    if (cmd.emit) begin
      byte_r  <= emit_byte;
      last_r  <= cmd.last;
      shown_r <= cmd.shown;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      acc_r       <= '0;
      nbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      acc_r       <= acc_nxt;
      nbits_r     <= nbits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign pix       = rd_hit_r ? rd_data_r : '0;
  assign gray      = gray_map(pix);
  assign emit_byte = BYTE_W'(acc_r >> (nbits_r - NBITS_W'(BYTE_W)));

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.wr_en) begin
      valid_nxt[cmd.wr_addr] = 1'b1;
    end

    acc_nxt   = acc_r;
    nbits_nxt = nbits_r;
    if (cmd.start) begin
      acc_nxt   = '0;
      nbits_nxt = NBITS_W'(PAD_BITS);
    end else begin
      if (cmd.emit) begin
        nbits_nxt = nbits_nxt - NBITS_W'(BYTE_W);
      end
      if (cmd.append) begin
        acc_nxt   = ACC_W'({acc_r, gray});
        nbits_nxt = nbits_nxt + NBITS_W'(GRAY_W);
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign status.bits_ge8  = nbits_r >= NBITS_W'(BYTE_W);
  assign status.bits_le8  = nbits_r <= NBITS_W'(BYTE_W);
  assign status.bits_le16 = nbits_r <= NBITS_W'(2 * BYTE_W);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_shift_byte  = byte_r;
  assign out_last_byte   = last_r;
  assign out_shown_layer = shown_r;

endmodule

[design/layered_led_grayscale_serializer.sv]
// Top level of the layered LED grayscale serializer.
// The input channel carries words of two kinds. A write word (command 0) stores
// pixel_value at pixel_index in the frame memory and leaves the input ready;
// an index beyond the frame is dropped. A tick word (command 1) enables the
// current layer, advances the layer counter and uploads the next layer.
// The upload is 41 result words on the output channel: four zero pad bits and
// then channels 26 down to 0 as 12-bit grayscale values, packed MSB first.
// Every result word reports the layer that was enabled; last_byte marks the end.
// With an open receiver the packer emits one byte a cycle, while the single-port
// frame memory supplies at most one channel a cycle; the first byte leaves through
// the state register, the memory read register, the packer and the output register.
// The input is not ready during an upload; writes are taken one a cycle otherwise.
// When the receiver stalls, the output register holds its word and the packer
// waits; the upload resumes without loss once ready returns.
// Reset clears the frame to zero, the layer counter to zero and the output.
module layered_led_grayscale_serializer (
  input logic        clk,
  input logic        rst_n,
  lgs_in_if.sink     in_ch,
  lgs_out_if.source  out_ch
);
  import lgs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lgs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_command     (in_ch.command),
    .in_pixel_index (in_ch.pixel_index),
    .in_ready       (in_ch.ready),
    .status         (status),
    .cmd            (cmd)
  );

  lgs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_pixel_value  (in_ch.pixel_value),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_shift_byte  (out_ch.shift_byte),
    .out_last_byte   (out_ch.last_byte),
    .out_shown_layer (out_ch.shown_layer)
  );

endmodule

[design/lgs_checker.sv]
// Port-level checks on the serializer, bound to the top level.
module lgs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lgs_pkg::BYTE_W-1:0]    out_shift_byte,
  input logic [lgs_pkg::SHOWN_W-1:0]   out_shown_layer
);
  import lgs_pkg::*;

  // A tick starts an upload, so no further word is taken in the next cycle.
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_TICK) |=> !in_ready)
    else $error("input ready right after a tick");

  // A write completes at once and leaves the input open.
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_WRITE) |=> in_ready)
    else $error("input stalled after a write");

  // The shown layer of a valid output word always names an existing layer.
  a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (LAYER_COUNT > 4 || int'(out_shown_layer) < LAYER_COUNT))
    else $error("shown layer out of range");

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_shift_byte)))
    else $error("stalled output word changed");

endmodule

bind layered_led_grayscale_serializer lgs_checker u_lgs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_shift_byte  (out_ch.shift_byte),
  .out_shown_layer (out_ch.shown_layer)
);
